>>> rtl/core/pta_pkg.sv
// Package for the requester tag allocator: constants, types and codes.
package pta_pkg;
  localparam int unsigned MaxRequesters = 16;
  localparam int unsigned TagsPerRequester = 256;
  localparam int unsigned TagSpace = 256;
  localparam int unsigned ReqIdxW = (MaxRequesters > 1) ? $clog2(MaxRequesters) : 1;
  localparam int unsigned ReqCntW = $clog2(MaxRequesters + 1);
  localparam int unsigned TagW = 8;
  localparam int unsigned SegW = 16;
  localparam int unsigned NumSeg = TagSpace / SegW;
  localparam int unsigned SegIdxW = $clog2(NumSeg);
  localparam int unsigned SegBitW = $clog2(SegW);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_READY   = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_TAG   = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;
endpackage

>>> rtl/core/pta_ram.sv
// Generic single-port synchronous RAM with registered read.
module pta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/core/pcie_tag_allocator.sv
// Requester tag allocator top level: requester match, map memory and tag search.
//
//   channel | ports                                   | dir
//   in      | in_valid in_stall in_action in_requester_id in_tag | in
//   out     | out_valid out_stall out_status out_slot_tag out_is_waiting out_is_ready | out
//
// Steps: key match, map read, tag search, map write, result; an unknown requester
// goes straight to the result and a new entry skips read and search. The key table
// is scanned one entry per cycle; allocate searches the tag space segment by segment.
// One transaction at a time: in_stall is high until the result has been taken.
// Reset clears the valid bits, the state and out_valid; a new entry writes a clean map word.
module pcie_tag_allocator
  import pta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [15:0]       in_requester_id,
  input  logic [TagW-1:0]   in_tag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [TagW-1:0]   out_slot_tag,
  output logic              out_is_waiting,
  output logic              out_is_ready
);
  localparam int unsigned MapW = 2 * TagSpace + TagW;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_READ, S_SEARCH, S_WRITE, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] act_r;
  logic [15:0] id_r;
  logic [TagW-1:0] tag_r;
  logic [MaxRequesters-1:0] valid_r;
  logic [ReqCntW-1:0] scan_r;
  logic [ReqIdxW-1:0] ent_r;
  logic fresh_r;
  logic [TagSpace-1:0] busy_r, rdy_r;
  logic [TagW-1:0] ptr_r;
  logic [SegIdxW:0] seg_r;
  logic [1:0] st_r;
  logic [TagW-1:0] stag_r;
  logic w_r, r_r;

  logic key_we, map_we;
  logic [ReqIdxW-1:0] key_addr, map_addr;
  logic [15:0] key_rd;
  logic [MapW-1:0] map_wd, map_rd;

  pta_ram #(.Width(16), .Depth(MaxRequesters)) u_keys (
    .clk(clk), .we(key_we), .addr(key_addr), .wdata(id_r), .rdata(key_rd)
  );
  pta_ram #(.Width(MapW), .Depth(MaxRequesters)) u_maps (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wd), .rdata(map_rd)
  );

  // scan_r addresses entry being read; its key is compared in the next cycle
  logic [ReqCntW-1:0] scan_prev;
  logic scan_hit;
  logic [ReqIdxW-1:0] scan_a, prev_a;
  assign scan_a = scan_r[ReqIdxW-1:0];
  assign scan_prev = scan_r - ReqCntW'(1);
  assign prev_a = scan_prev[ReqIdxW-1:0];
  assign scan_hit = (scan_r != '0) && valid_r[prev_a] && (key_rd == id_r);

  assign key_we = (state_r == S_MATCH) && fresh_r;
  assign key_addr = (state_r == S_MATCH && !fresh_r) ? scan_a : ent_r;
  assign map_we = (state_r == S_WRITE);
  assign map_addr = ent_r;
  assign map_wd = {ptr_r, rdy_r, busy_r};

  // segment search: candidate bits in one 16-tag segment
  logic [SegIdxW-1:0] seg_i, ptr_seg;
  logic [SegW-1:0] seg_free;
  logic seg_found;
  logic [SegBitW-1:0] seg_pos;
  logic [TagW-1:0] found_tag;
  logic wrapped;
  assign wrapped = (seg_r >= (SegIdxW+1)'(NumSeg));
  assign ptr_seg = ptr_r[TagW-1 -: SegIdxW];
  assign seg_i = ptr_seg + seg_r[SegIdxW-1:0];

  always_comb begin
    logic [TagW-1:0] t;
    seg_free = '0;
    for (int b = 0; b < SegW; b++) begin
      t = {seg_i, SegBitW'(b)};
      seg_free[b] = !busy_r[t] && (int'(t) < TagsPerRequester);
      // first segment: only at or after pointer; wrap pass: only before
      if (seg_r == '0 && SegBitW'(b) < ptr_r[SegBitW-1:0]) seg_free[b] = 1'b0;
      if (wrapped && SegBitW'(b) >= ptr_r[SegBitW-1:0]) seg_free[b] = 1'b0;
    end
    seg_found = |seg_free;
    seg_pos = '0;
    for (int b = SegW - 1; b >= 0; b--) begin
      if (seg_free[b]) seg_pos = SegBitW'(b);
    end
    found_tag = {seg_i, seg_pos};
  end

  logic [ReqCntW-1:0] nvalid;
  always_comb begin
    nvalid = ReqCntW'(MaxRequesters);
    for (int i = MaxRequesters - 1; i >= 0; i--) begin
      if (!valid_r[i]) nvalid = ReqCntW'(i);
    end
  end

  logic tag_ok;
  assign tag_ok = (int'(tag_r) < TagsPerRequester);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            id_r <= in_requester_id;
            tag_r <= in_tag;
            scan_r <= '0;
            fresh_r <= 1'b0;
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (fresh_r) begin
            state_r <= S_WRITE;
          end else if (scan_hit) begin
            ent_r <= prev_a;
            scan_r <= '0;
            state_r <= S_READ;
          end else if (scan_r == ReqCntW'(MaxRequesters)) begin
            stag_r <= (act_r == ACT_ALLOC) ? '0 : tag_r;
            w_r <= 1'b0;
            r_r <= 1'b0;
            if (act_r != ACT_ALLOC) begin
              st_r <= ST_UNKNOWN;
              state_r <= S_OUT;
            end else if (nvalid == ReqCntW'(MaxRequesters)) begin
              st_r <= ST_FULL;
              state_r <= S_OUT;
            end else begin
              // fresh entry: first tag is zero; key written next cycle
              ent_r <= nvalid[ReqIdxW-1:0];
              valid_r[nvalid[ReqIdxW-1:0]] <= 1'b1;
              fresh_r <= 1'b1;
              busy_r <= TagSpace'(1);
              rdy_r <= '0;
              ptr_r <= '0;
              st_r <= ST_OK;
              w_r <= 1'b1;
            end
          end else begin
            scan_r <= scan_r + ReqCntW'(1);
          end
        end
        S_READ: begin
          // addresses the entry first, then takes the registered read data
          if (scan_r == '0) begin
            scan_r <= ReqCntW'(1);
          end else begin
            busy_r <= map_rd[TagSpace-1:0];
            rdy_r <= map_rd[2*TagSpace-1:TagSpace];
            ptr_r <= map_rd[MapW-1 -: TagW];
            seg_r <= '0;
            st_r <= ST_OK;
            stag_r <= (act_r == ACT_ALLOC) ? '0 : tag_r;
            w_r <= 1'b0;
            r_r <= 1'b0;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (act_r != ACT_ALLOC) begin
            if (tag_ok) begin
              if (act_r == ACT_READY) rdy_r[tag_r] <= 1'b1;
              if (act_r == ACT_RELEASE) busy_r[tag_r] <= 1'b0;
              w_r <= (act_r == ACT_RELEASE) ? 1'b0 : busy_r[tag_r];
              r_r <= (act_r == ACT_READY) ? 1'b1 : rdy_r[tag_r];
            end
            state_r <= S_WRITE;
          end else if (seg_found) begin
            busy_r[found_tag] <= 1'b1;
            rdy_r[found_tag] <= 1'b0;
            ptr_r <= found_tag;
            stag_r <= found_tag;
            w_r <= 1'b1;
            state_r <= S_WRITE;
          end else if (seg_r == (SegIdxW+1)'(NumSeg)) begin
            st_r <= ST_NO_TAG;
            state_r <= S_OUT;
          end else begin
            seg_r <= seg_r + 1'b1;
          end
        end
        S_WRITE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_status <= st_r;
            out_slot_tag <= stag_r;
            out_is_waiting <= w_r;
            out_is_ready <= r_r;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  a_alloc_ok_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && act_r == ACT_ALLOC && out_status == ST_OK)
    |-> (out_is_waiting && !out_is_ready))
    else $error("allocated tag not reported waiting and not ready");
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |=> state_r == S_OUT) else $error("write-back stalled");
`endif
endmodule

>>> tb/pcie_tag_allocator_checker.sv
// Checker for the requester tag allocator: predicts each result and compares.
module pcie_tag_allocator_checker
  import pta_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [1:0]      in_action,
  input  logic [15:0]     in_requester_id,
  input  logic [TagW-1:0] in_tag,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [1:0]      out_status,
  input  logic [TagW-1:0] out_slot_tag,
  input  logic            out_is_waiting,
  input  logic            out_is_ready,
  output int              fail_count,
  output int              pending_count
);

  typedef struct packed {
    status_t         status;
    logic [TagW-1:0] slot_tag;
    logic            waiting;
    logic            ready;
  } tag_result_t;

  logic [15:0]          req_key   [MaxRequesters];
  logic                 req_used  [MaxRequesters];
  logic [TagW-1:0]      rot_ptr   [MaxRequesters];
  logic [TagSpace-1:0]  busy_bits [MaxRequesters];
  logic [TagSpace-1:0]  ready_bits[MaxRequesters];
  tag_result_t          expected_results[$];

  assign pending_count = expected_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic tag_result_t predict_tag_result(action_t act, logic [15:0] rid,
                                                      logic [TagW-1:0] tg);
    tag_result_t res;
    int e;
    int idx;
    bit found;
    e = -1;
    found = 0;
    res = '{ST_OK, tg, 1'b0, 1'b0};
    for (int i = 0; i < MaxRequesters; i++)
      if (e < 0 && req_used[i] && req_key[i] == rid) e = i;
    if (act == ACT_ALLOC) begin
      res.slot_tag = '0;
      if (e < 0) begin
        for (int i = 0; i < MaxRequesters; i++)
          if (e < 0 && !req_used[i]) e = i;
        if (e >= 0) begin
          req_used[e] = 1'b1;
          req_key[e] = rid;
          rot_ptr[e] = '0;
          busy_bits[e] = '0;
          ready_bits[e] = '0;
        end else res.status = ST_FULL;
      end
      if (e >= 0) begin
        for (int k = 0; k < TagsPerRequester; k++) begin
          idx = (rot_ptr[e] + k) % TagsPerRequester;
          if (!found && !busy_bits[e][idx]) begin
            found = 1;
            busy_bits[e][idx] = 1'b1;
            ready_bits[e][idx] = 1'b0;
            rot_ptr[e] = idx[TagW-1:0];
            res.slot_tag = idx[TagW-1:0];
            res.waiting = 1'b1;
          end
        end
        if (!found) res.status = ST_NO_TAG;
      end
    end else if (e < 0) begin
      res.status = ST_UNKNOWN;
    end else if (tg < TagsPerRequester) begin
      if (act == ACT_READY) ready_bits[e][tg] = 1'b1;
      else if (act == ACT_RELEASE) busy_bits[e][tg] = 1'b0;
      res.waiting = busy_bits[e][tg];
      res.ready = ready_bits[e][tg];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    tag_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
      for (int i = 0; i < MaxRequesters; i++) begin
        req_used[i] = 1'b0;
        rot_ptr[i] = '0;
        busy_bits[i] = '0;
        ready_bits[i] = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status != want.status) report("status", out_status, want.status);
          if (out_slot_tag != want.slot_tag) report("slot_tag", out_slot_tag, want.slot_tag);
          if (out_is_waiting != want.waiting) report("is_waiting", out_is_waiting, want.waiting);
          if (out_is_ready != want.ready) report("is_ready", out_is_ready, want.ready);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_tag_result(action_t'(in_action),
                                                      in_requester_id, in_tag));
    end
  end

endmodule

>>> tb/pcie_tag_allocator_tb.sv
// Testbench top for the requester tag allocator: stimulus, stalls and verdict.
module pcie_tag_allocator_tb;
  import pta_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      in_action = ACT_LOOKUP;
  logic [15:0]     in_requester_id = '0;
  logic [TagW-1:0] in_tag = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [1:0]      out_status;
  logic [TagW-1:0] out_slot_tag;
  logic            out_is_waiting;
  logic            out_is_ready;
  int              fail_count;
  int              pending_count;
  int              cycle_count = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  bit              hold_off = 1'b0;
  logic [15:0]     known_ids[$];

  pcie_tag_allocator uut (.*);
  pcie_tag_allocator_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);

  // valid stays high between back-to-back transactions; callers drop it
  task automatic send(input action_t act, input logic [15:0] rid, input logic [TagW-1:0] tg);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_requester_id <= rid;
    in_tag <= tg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [15:0] rid;
    int pick;
    pick = $urandom_range(99);
    if (known_ids.size() == 0 || pick < 8) rid = 16'($urandom);
    else rid = known_ids[$urandom_range(known_ids.size() - 1)];
    pick = $urandom_range(99);
    if (pick < 45) begin
      send(ACT_ALLOC, rid, TagW'($urandom));
      if (known_ids.size() < 24) known_ids.push_back(rid);
    end else if (pick < 60) send(ACT_LOOKUP, rid, TagW'($urandom_range(15)));
    else if (pick < 80)
      send(ACT_READY, rid,
           TagW'(($urandom_range(3) == 0) ? $urandom : $urandom_range(15)));
    else
      send(ACT_RELEASE, rid,
           TagW'(($urandom_range(3) == 0) ? $urandom : $urandom_range(15)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: unknown requester, fresh entry, extremes of the tag
    send(ACT_LOOKUP, 16'hFFFF, 8'hFF);
    send(ACT_ALLOC, 16'hFFFF, 8'hAA);
    send(ACT_ALLOC, 16'hFFFF, 8'h55);
    send(ACT_READY, 16'hFFFF, 8'd0);
    send(ACT_LOOKUP, 16'hFFFF, 8'd0);
    send(ACT_READY, 16'hFFFF, 8'hFF);
    send(ACT_RELEASE, 16'hFFFF, 8'd0);
    send(ACT_LOOKUP, 16'hFFFF, 8'd0);
    send(ACT_ALLOC, 16'hFFFF, 8'd0);
    send(ACT_RELEASE, 16'h0000, 8'd1);
    send(ACT_READY, 16'h0000, 8'd1);
    for (int i = 0; i < 16; i++) send(ACT_ALLOC, 16'(16'h1000 + i), 8'd0);
    // the whole tag space of one requester, then no free tag
    for (int i = 0; i < 256; i++) send(ACT_ALLOC, 16'hFFFF, 8'd0);
    send(ACT_RELEASE, 16'hFFFF, 8'd77);
    send(ACT_ALLOC, 16'hFFFF, 8'd0);
    send(ACT_ALLOC, 16'hFFFF, 8'd0);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    // long receiver hold-off while input keeps coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send(ACT_LOOKUP, 16'(16'h1000 + i), TagW'(i));
    join
    known_ids.push_back(16'hFFFF);
    for (int i = 0; i < 14; i++) known_ids.push_back(16'(16'h1000 + i));
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 55) : 0;
      stall_pct = (ph == 2) ? 55 : ((ph == 3) ? 11 : 0);
      for (int i = 0; i < 25; i++) send_random();
    end
    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> pcie_tag_allocator.f
rtl/core/pta_pkg.sv
rtl/core/pta_ram.sv
rtl/core/pcie_tag_allocator.sv
tb/pcie_tag_allocator_checker.sv
tb/pcie_tag_allocator_tb.sv
